[hw/rtl/fcrmse_pkg.sv]
// ----------------------------------------------------------------------------
// fcrmse_pkg
// Shared widths, lane types and controller/datapath command and status
// bundles of the four-channel RMSE block.
// ----------------------------------------------------------------------------
package fcrmse_pkg;

   // Sample and result format: Q16.16
   localparam int DATA_W      = 32;
   localparam int NUM_CH      = 4;
   localparam int SQ_W        = 2 * DATA_W;              // Q32.32 square and sum
   localparam int MAX_SAMPLES = 65536;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

   // Iterative units: one quotient bit, then one root bit per cycle
   localparam int DIV_STEPS   = SQ_W;
   localparam int SQRT_STEPS  = SQ_W / 2;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int SQ_REM_W    = ROOT_W + 2;

   typedef logic [NUM_CH-1:0][DATA_W-1:0] lane_word_type;

   typedef struct packed {
      logic load;        // sample beat accepted this cycle
      logic div_start;   // clear remainder and root registers
      logic div_step;    // advance the divider by one quotient bit
      logic sqrt_step;   // advance the square root by one root bit
      logic clear;       // result taken: return to the empty batch
   } fcrmse_cmd_type;

   typedef struct packed {
      logic pipe_busy;   // a sample is still on its way to the sums
   } fcrmse_status_type;

endpackage

[hw/rtl/fcrmse_if.sv]
// ----------------------------------------------------------------------------
// fcrmse_if
// Valid/ready channels of the four-channel RMSE block: sample pair beats in,
// RMSE result beats out.
// ----------------------------------------------------------------------------
interface fcrmse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fcrmse_pkg::DATA_W-1:0] est_x;
   logic signed [fcrmse_pkg::DATA_W-1:0] est_y;
   logic signed [fcrmse_pkg::DATA_W-1:0] est_vx;
   logic signed [fcrmse_pkg::DATA_W-1:0] est_vy;
   logic signed [fcrmse_pkg::DATA_W-1:0] true_x;
   logic signed [fcrmse_pkg::DATA_W-1:0] true_y;
   logic signed [fcrmse_pkg::DATA_W-1:0] true_vx;
   logic signed [fcrmse_pkg::DATA_W-1:0] true_vy;
   logic                                 last_sample;

   modport source (
      output valid, est_x, est_y, est_vx, est_vy,
             true_x, true_y, true_vx, true_vy, last_sample,
      input  ready
   );
   modport sink (
      input  valid, est_x, est_y, est_vx, est_vy,
             true_x, true_y, true_vx, true_vy, last_sample,
      output ready
   );
endinterface

interface fcrmse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcrmse_pkg::DATA_W-1:0] rmse_x;
   logic [fcrmse_pkg::DATA_W-1:0] rmse_y;
   logic [fcrmse_pkg::DATA_W-1:0] rmse_vx;
   logic [fcrmse_pkg::DATA_W-1:0] rmse_vy;
   logic                          overflow;

   modport source (
      output valid, rmse_x, rmse_y, rmse_vx, rmse_vy, overflow,
      input  ready
   );
   modport sink (
      input  valid, rmse_x, rmse_y, rmse_vx, rmse_vy, overflow,
      output ready
   );
endinterface

[hw/rtl/fcrmse_datapath.sv]
// ----------------------------------------------------------------------------
// fcrmse_datapath
// Residual / square / accumulate pipeline, four lanes wide, followed by a
// restoring divider and a digit-by-digit square root that reuse the sum
// registers as their shift registers.
// ----------------------------------------------------------------------------
module fcrmse_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  fcrmse_pkg::fcrmse_cmd_type    cmd,
   input  fcrmse_pkg::lane_word_type     est,
   input  fcrmse_pkg::lane_word_type     tru,
   output fcrmse_pkg::fcrmse_status_type status,
   output fcrmse_pkg::lane_word_type     rmse,
   output logic                          overflow
);

   localparam logic [fcrmse_pkg::DATA_W-1:0] POS_MAG =
      {1'b0, {(fcrmse_pkg::DATA_W-1){1'b1}}};
   localparam logic [fcrmse_pkg::DATA_W-1:0] NEG_MAG =
      {1'b1, {(fcrmse_pkg::DATA_W-1){1'b0}}};
   localparam logic [fcrmse_pkg::COUNT_W-1:0] COUNT_MAX =
      fcrmse_pkg::COUNT_W'(fcrmse_pkg::MAX_SAMPLES);

   // Stage A: saturated residual magnitudes
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::DATA_W-1:0] mag_ff, mag_in;
   logic valid_a_ff, sat_a_ff, sat_a_in;
   // Stage B: squares
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::SQ_W-1:0] sq_ff;
   logic valid_b_ff, sat_b_ff;
   // Stage C: running sums, also the divider / root shift registers
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::SQ_W-1:0] sums_ff, sums_in;
   logic [fcrmse_pkg::COUNT_W-1:0] count_ff, count_in;
   logic flag_ff, flag_in;
   // Divider and root working registers
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::COUNT_W-1:0]  div_rem_ff, div_rem_in;
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::SQ_REM_W-1:0] sq_rem_ff, sq_rem_in;
   logic [fcrmse_pkg::NUM_CH-1:0][fcrmse_pkg::ROOT_W-1:0]   root_ff, root_in;

   // Residual, clamp to 32 bits signed, take magnitude
   always_comb begin
      logic [fcrmse_pkg::DATA_W:0] diff;
      diff     = '0;
      sat_a_in = 1'b0;
      for (int k = 0; k < fcrmse_pkg::NUM_CH; k++) begin
         diff = {est[k][fcrmse_pkg::DATA_W-1], est[k]}
              - {tru[k][fcrmse_pkg::DATA_W-1], tru[k]};
         if (diff[fcrmse_pkg::DATA_W] != diff[fcrmse_pkg::DATA_W-1]) begin
            sat_a_in  = 1'b1;
            mag_in[k] = diff[fcrmse_pkg::DATA_W] ? NEG_MAG : POS_MAG;
         end else if (diff[fcrmse_pkg::DATA_W-1]) begin
            mag_in[k] = -diff[fcrmse_pkg::DATA_W-1:0];
         end else begin
            mag_in[k] = diff[fcrmse_pkg::DATA_W-1:0];
         end
      end
   end

   // Clear, accumulate, divide and root steps
   always_comb begin
      logic [fcrmse_pkg::SQ_W:0]        acc;
      logic [fcrmse_pkg::COUNT_W:0]     drem;
      logic                             dge;
      logic [fcrmse_pkg::SQ_REM_W+1:0]  srem;
      logic [fcrmse_pkg::SQ_REM_W+1:0]  trial;
      logic                             sge;
      acc        = '0;
      drem       = '0;
      dge        = 1'b0;
      srem       = '0;
      trial      = '0;
      sge        = 1'b0;
      sums_in    = sums_ff;
      count_in   = count_ff;
      flag_in    = flag_ff;
      div_rem_in = div_rem_ff;
      sq_rem_in  = sq_rem_ff;
      root_in    = root_ff;
      priority if (cmd.clear) begin
         sums_in  = '0;
         count_in = '0;
         flag_in  = 1'b0;
      end else if (cmd.div_start) begin
         div_rem_in = '0;
         sq_rem_in  = '0;
         root_in    = '0;
      end else if (cmd.div_step) begin
         for (int k = 0; k < fcrmse_pkg::NUM_CH; k++) begin
            drem = {div_rem_ff[k], sums_ff[k][fcrmse_pkg::SQ_W-1]};
            dge  = drem >= {1'b0, count_ff};
            div_rem_in[k] = dge ? fcrmse_pkg::COUNT_W'(drem - {1'b0, count_ff})
                                : drem[fcrmse_pkg::COUNT_W-1:0];
            sums_in[k] = {sums_ff[k][fcrmse_pkg::SQ_W-2:0], dge};
         end
      end else if (cmd.sqrt_step) begin
         for (int k = 0; k < fcrmse_pkg::NUM_CH; k++) begin
            srem  = {sq_rem_ff[k], sums_ff[k][fcrmse_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, root_ff[k], 2'b01};
            sge   = srem >= trial;
            sq_rem_in[k] = sge ? fcrmse_pkg::SQ_REM_W'(srem - trial)
                               : srem[fcrmse_pkg::SQ_REM_W-1:0];
            root_in[k]   = {root_ff[k][fcrmse_pkg::ROOT_W-2:0], sge};
            sums_in[k]   = {sums_ff[k][fcrmse_pkg::SQ_W-3:0], 2'b00};
         end
      end else if (valid_b_ff) begin
         flag_in = flag_ff | sat_b_ff;
         for (int k = 0; k < fcrmse_pkg::NUM_CH; k++) begin
            acc = {1'b0, sums_ff[k]} + {1'b0, sq_ff[k]};
            if (acc[fcrmse_pkg::SQ_W]) begin
               sums_in[k] = '1;
               flag_in    = 1'b1;
            end else begin
               sums_in[k] = acc[fcrmse_pkg::SQ_W-1:0];
            end
         end
         if (count_ff == COUNT_MAX) begin
            flag_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // Hold pipeline control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         sat_a_ff   <= 1'b0;
         sat_b_ff   <= 1'b0;
         sums_ff    <= '0;
         count_ff   <= '0;
         flag_ff    <= 1'b0;
      end else begin
         valid_a_ff <= cmd.load;
         valid_b_ff <= valid_a_ff;
         sat_a_ff   <= cmd.load & sat_a_in;
         sat_b_ff   <= sat_a_ff;
         sums_ff    <= sums_in;
         count_ff   <= count_in;
         flag_ff    <= flag_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_in;
      end
      for (int k = 0; k < fcrmse_pkg::NUM_CH; k++) begin
         sq_ff[k] <= fcrmse_pkg::SQ_W'(mag_ff[k]) * fcrmse_pkg::SQ_W'(mag_ff[k]);
      end
      div_rem_ff <= div_rem_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
   end

   assign status.pipe_busy = valid_a_ff | valid_b_ff;
   assign rmse             = root_ff;
   assign overflow         = flag_ff;

   // Count never passes its ceiling
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_MAX)
      else $error("sample count above ceiling");

   // Taking the result empties the batch
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0 && !flag_ff))
      else $error("batch not emptied after result");

   // No square lands in the sums while they serve as shift registers
   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.sqrt_step) |-> !valid_b_ff)
      else $error("square pending during divide or root");

endmodule

[hw/rtl/fcrmse_ctrl.sv]
// ----------------------------------------------------------------------------
// fcrmse_ctrl
// Sequencer: accepts sample beats, drains the pipeline after the last beat,
// runs the divider and root steps and hands out the result beat.
// ----------------------------------------------------------------------------
module fcrmse_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_last,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  fcrmse_pkg::fcrmse_status_type status,
   output fcrmse_pkg::fcrmse_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_DIV,
      ST_SQRT,
      ST_SEND
   } state_type;

   state_type state_ff;
   logic [fcrmse_pkg::STEP_W-1:0] step_ff;
   logic req_fire;

   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = (state_ff == ST_SEND);
   assign req_fire  = req_valid & req_ready;

   // Decode commands
   always_comb begin
      cmd           = '0;
      cmd.load      = req_fire;
      cmd.div_start = (state_ff == ST_DRAIN) && !status.pipe_busy;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.clear     = (state_ff == ST_SEND) && rsp_ready;
   end

   // Hold state and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_ACCUM: begin
               if (req_fire && req_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!status.pipe_busy) begin
                  state_ff <= ST_DIV;
                  step_ff  <= '0;
               end
            end
            ST_DIV: begin
               if (step_ff == fcrmse_pkg::STEP_W'(fcrmse_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_SQRT;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               if (step_ff == fcrmse_pkg::STEP_W'(fcrmse_pkg::SQRT_STEPS - 1)) begin
                  state_ff <= ST_SEND;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  state_ff <= ST_ACCUM;
               end
            end
            default: begin
               state_ff <= ST_ACCUM;
            end
         endcase
      end
   end

   // The last beat closes the input until the result is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=> !req_ready)
      else $error("input open after last beat");

   // Divider never steps while a sample is still in flight
   assert property (@(posedge clock) disable iff (reset)
      status.pipe_busy |-> !(cmd.div_step || cmd.sqrt_step || cmd.div_start))
      else $error("divide started before pipeline drained");

   // Divider start is followed by a divide step
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> cmd.div_step)
      else $error("divide start without divide step");

   // Result beat and sample beats never overlap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result offered while accepting samples");

endmodule

[hw/rtl/four_channel_rmse.sv]
// ----------------------------------------------------------------------------
// four_channel_rmse
// Root mean square error of four state components over a batch of samples.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle while a batch accumulates.
// After the last beat the pipeline drains, then the divider steps and the
//   root steps run, and the result beat is offered when the root is done.
// No beat is accepted from the last beat until the result beat is taken.
// Reset (synchronous, active high) empties the batch: sums, count, flag.
// ----------------------------------------------------------------------------
module four_channel_rmse (
   input  logic clock,
   input  logic reset,
   fcrmse_req_if.sink   req_bus,
   fcrmse_rsp_if.source rsp_bus
);

   fcrmse_pkg::fcrmse_cmd_type    cmd;
   fcrmse_pkg::fcrmse_status_type status;
   fcrmse_pkg::lane_word_type     est;
   fcrmse_pkg::lane_word_type     tru;
   fcrmse_pkg::lane_word_type     rmse;
   logic                          overflow;

   // Gather lanes
   assign est[0] = req_bus.est_x;
   assign est[1] = req_bus.est_y;
   assign est[2] = req_bus.est_vx;
   assign est[3] = req_bus.est_vy;
   assign tru[0] = req_bus.true_x;
   assign tru[1] = req_bus.true_y;
   assign tru[2] = req_bus.true_vx;
   assign tru[3] = req_bus.true_vy;

   fcrmse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_sample),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcrmse_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .est      (est),
      .tru      (tru),
      .status   (status),
      .rmse     (rmse),
      .overflow (overflow)
   );

   // Drive result beat
   assign rsp_bus.rmse_x   = rmse[0];
   assign rsp_bus.rmse_y   = rmse[1];
   assign rsp_bus.rmse_vx  = rmse[2];
   assign rsp_bus.rmse_vy  = rmse[3];
   assign rsp_bus.overflow = overflow;

endmodule
